@@ rtl/sdsh_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsh_pkg
// Shared types and constants of the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsh_pkg;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_CARD  = 3'd3,
    OP_LOAD  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_CMD_TIMEOUT  = 2'd1,
    ST_DATA_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_DUMMY   = 5'd1,
    PH_F_CMD0  = 5'd2,
    PH_P_CMD0  = 5'd3,
    PH_GAP1    = 5'd4,
    PH_F_CMD8  = 5'd5,
    PH_P_CMD8A = 5'd6,
    PH_P_CMD8B = 5'd7,
    PH_GAP2    = 5'd8,
    PH_F_CMD1  = 5'd9,
    PH_P_CMD1  = 5'd10,
    PH_TAIL    = 5'd11,
    PH_F_RD    = 5'd12,
    PH_P_RD    = 5'd13,
    PH_RTOK    = 5'd14,
    PH_RDATA   = 5'd15,
    PH_F_WR    = 5'd16,
    PH_P_WR    = 5'd17,
    PH_WGAP    = 5'd18,
    PH_WTOK    = 5'd19,
    PH_WDATA   = 5'd20,
    PH_WRESP   = 5'd21
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SEND,
    ACT_FINISH,
    ACT_DATA_SEND,
    ACT_DATA_FINISH
  } act_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] block_address;
    logic        skip_data;
    logic [7:0]  card_byte;
    logic [8:0]  load_index;
    logic [7:0]  load_data;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [8:0] byte_index;
    logic       chip_select_low;
    status_e    status;
    logic       card_v2;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] beats;
    result_t    r0;
    result_t    r1;
  } push_t;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] CMD0_BYTE   = 8'h40;
  localparam logic [7:0] CMD1_BYTE   = 8'h41;
  localparam logic [7:0] CMD8_BYTE   = 8'h48;
  localparam logic [7:0] CMD17_BYTE  = 8'h51;
  localparam logic [7:0] CMD24_BYTE  = 8'h58;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD1    = 8'hF9;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] DATA_TOKEN  = 8'hFE;
  localparam logic [7:0] RESP_ACC_A  = 8'h05;
  localparam logic [7:0] RESP_ACC_B  = 8'hE5;
  localparam logic [7:0] CHECK_ECHO  = 8'hAA;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;

  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [31:0] ARG_CMD1_HC = 32'h4000_0000;

  localparam int LEAD_DUMMIES  = 11;
  localparam int GAP_DUMMIES   = 5;
  localparam logic [2:0] FRAME_LAST = 3'd5;
  localparam logic [10:0] RD_TOKEN_POLLS = 11'd36;
  localparam logic [10:0] WR_RESP_POLLS  = 11'd1024;

endpackage

`default_nettype wire

@@ rtl/sdsh_wbuf.sv @@
// ----------------------------------------------------------------------------
// sdsh_wbuf
// Write data buffer with a registered read port and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_wbuf #(
  parameter int BLOCK_BYTES = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           load_en_i,
  input  wire logic [8:0]                     load_index_i,
  input  wire logic [7:0]                     load_data_i,
  input  wire logic [$clog2(BLOCK_BYTES)-1:0] rd_addr_i,
  output logic [7:0]                          rd_data_o
);

  localparam int AW = $clog2(BLOCK_BYTES);

  logic [7:0]    mem_q [BLOCK_BYTES];
  logic [7:0]    rd_q;
  logic          we;
  logic [AW-1:0] waddr;

  assign we        = load_en_i && (32'(load_index_i) < 32'(BLOCK_BYTES));
  assign waddr     = AW'(load_index_i);
  assign rd_data_o = rd_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= load_data_i;
    end
  end

  // read address follows the next state, so data is ready for the next beat
  always_ff @(posedge clk_i) begin
    if (we && (waddr == rd_addr_i)) begin
      rd_q <= load_data_i;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sdsh_core.sv @@
// ----------------------------------------------------------------------------
// sdsh_core
// Byte-level sequencer: one card exchange or request per beat, up to two
// result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_core import sdsh_pkg::*; #(
  parameter int BLOCK_BYTES = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           proc_i,
  input  wire item_t                          item_i,
  input  wire logic [7:0]                     rd_data_i,
  output logic [$clog2(BLOCK_BYTES)-1:0]      rd_addr_o,
  output push_t                               push_o
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] BLK        = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0] LEAD_LIMIT = CW'(LEAD_DUMMIES);
  localparam logic [CW-1:0] GAP_LIMIT  = CW'(GAP_DUMMIES);

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [10:0] budget_q, budget_d, budget_t;
  logic [4:0]  attempt_q, attempt_d;
  logic [CW-1:0] bc_q, bc_d, bc_inc;
  logic [31:0] addr_q, addr_d;
  logic        skip_q, skip_d;
  logic        v2_q, v2_d;
  status_e     fail_q, fail_d;

  act_e        act;
  logic [7:0]  tx;
  logic        after_en, after_ok, retry_en;
  phase_e      after_f, retry_f, frame_f;
  logic [7:0]  c;
  result_t     res_send, res_done, res_data;

  function automatic logic [7:0] frame_byte(phase_e ph, logic [2:0] pos, logic v2,
                                            logic [31:0] addr);
    logic [7:0]  cmd;
    logic [7:0]  crc;
    logic [31:0] arg;
    logic [7:0]  b;
    unique case (ph)
      PH_F_CMD0: begin
        cmd = CMD0_BYTE;  arg = '0;       crc = CRC_CMD0;
      end
      PH_F_CMD8: begin
        cmd = CMD8_BYTE;  arg = ARG_CMD8; crc = CRC_CMD8;
      end
      PH_F_CMD1: begin
        cmd = CMD1_BYTE;  arg = v2 ? ARG_CMD1_HC : '0; crc = CRC_CMD1;
      end
      PH_F_RD: begin
        cmd = CMD17_BYTE; arg = addr;     crc = BYTE_IDLE;
      end
      default: begin
        cmd = CMD24_BYTE; arg = addr;     crc = BYTE_IDLE;
      end
    endcase
    unique case (pos)
      3'd0:    b = cmd;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  function automatic logic [10:0] poll_len(phase_e f);
    logic [10:0] n;
    unique case (f)
      PH_F_CMD0: n = 11'd15;
      PH_F_CMD8: n = 11'd16;
      PH_F_CMD1: n = 11'd5;
      PH_F_RD:   n = 11'd6;
      default:   n = 11'd8;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] max_tries(phase_e f);
    logic [4:0] n;
    unique case (f)
      PH_F_CMD0: n = 5'd11;
      PH_F_CMD8: n = 5'd4;
      PH_F_CMD1: n = 5'd21;
      default:   n = 5'd5;
    endcase
    return n;
  endfunction

  function automatic phase_e poll_of(phase_e f);
    phase_e p;
    unique case (f)
      PH_F_CMD0: p = PH_P_CMD0;
      PH_F_CMD8: p = PH_P_CMD8A;
      PH_F_CMD1: p = PH_P_CMD1;
      PH_F_RD:   p = PH_P_RD;
      default:   p = PH_P_WR;
    endcase
    return p;
  endfunction

  function automatic phase_e frame_of(phase_e p);
    phase_e f;
    unique case (p)
      PH_P_CMD0:  f = PH_F_CMD0;
      PH_P_CMD8A: f = PH_F_CMD8;
      PH_P_CMD1:  f = PH_F_CMD1;
      PH_P_RD:    f = PH_F_RD;
      default:    f = PH_F_WR;
    endcase
    return f;
  endfunction

  assign c = item_i.card_byte;

  // next state
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    budget_d  = budget_q;
    attempt_d = attempt_q;
    bc_d      = bc_q;
    addr_d    = addr_q;
    skip_d    = skip_q;
    v2_d      = v2_q;
    fail_d    = fail_q;
    act       = ACT_NONE;
    tx        = BYTE_IDLE;
    after_en  = 1'b0;
    after_ok  = 1'b0;
    after_f   = PH_F_CMD0;
    retry_en  = 1'b0;
    retry_f   = PH_F_CMD0;
    budget_t  = (budget_q != '0) ? budget_q - 11'd1 : '0;
    bc_inc    = bc_q + 1'b1;
    frame_f   = frame_of(phase_q);

    if (proc_i) begin
      unique case (item_i.opcode)
        OP_INIT: begin
          if (phase_q == PH_IDLE) begin
            fail_d  = ST_OK;
            v2_d    = 1'b0;
            phase_d = PH_DUMMY;
            bc_d    = '0;
            act     = ACT_SEND;
          end
        end
        OP_READ, OP_WRITE: begin
          if (phase_q == PH_IDLE) begin
            fail_d    = ST_OK;
            addr_d    = item_i.block_address;
            if (item_i.opcode == OP_WRITE) begin
              skip_d = item_i.skip_data;
            end
            attempt_d = '0;
            phase_d   = (item_i.opcode == OP_READ) ? PH_F_RD : PH_F_WR;
            pos_d     = '0;
            act       = ACT_SEND;
            tx        = (item_i.opcode == OP_READ) ? CMD17_BYTE : CMD24_BYTE;
          end
        end
        OP_CARD: begin
          unique case (phase_q)
            PH_IDLE: ;
            PH_DUMMY, PH_GAP1, PH_GAP2, PH_TAIL: begin
              bc_d = bc_inc;
              if (bc_inc < ((phase_q == PH_DUMMY) ? LEAD_LIMIT : GAP_LIMIT)) begin
                act = ACT_SEND;
              end else if (phase_q == PH_TAIL) begin
                phase_d = PH_IDLE;
                act     = ACT_FINISH;
              end else begin
                attempt_d = '0;
                pos_d     = '0;
                act       = ACT_SEND;
                priority if (phase_q == PH_DUMMY) begin
                  phase_d = PH_F_CMD0;
                  tx      = CMD0_BYTE;
                end else if (phase_q == PH_GAP1) begin
                  phase_d = PH_F_CMD8;
                  tx      = CMD8_BYTE;
                end else begin
                  phase_d = PH_F_CMD1;
                  tx      = CMD1_BYTE;
                end
              end
            end
            PH_F_CMD0, PH_F_CMD8, PH_F_CMD1, PH_F_RD, PH_F_WR: begin
              act = ACT_SEND;
              if (pos_q < FRAME_LAST) begin
                pos_d = pos_q + 3'd1;
                tx    = frame_byte(phase_q, pos_d, v2_q, addr_q);
              end else begin
                budget_d = poll_len(phase_q);
                phase_d  = poll_of(phase_q);
              end
            end
            PH_P_CMD0, PH_P_CMD8A, PH_P_CMD1, PH_P_RD, PH_P_WR: begin
              budget_d = budget_t;
              if (c == (((frame_f == PH_F_CMD0) || (frame_f == PH_F_CMD8)) ?
                        R1_IDLE : R1_READY)) begin
                if (frame_f == PH_F_CMD8) begin
                  phase_d = PH_P_CMD8B;
                  act     = ACT_SEND;
                end else begin
                  after_en = 1'b1;
                  after_ok = 1'b1;
                  after_f  = frame_f;
                end
              end else if (budget_t != '0) begin
                act = ACT_SEND;
              end else begin
                retry_en = 1'b1;
                retry_f  = frame_f;
              end
            end
            PH_P_CMD8B: begin
              budget_d = budget_t;
              if (c == CHECK_ECHO) begin
                after_en = 1'b1;
                after_ok = 1'b1;
                after_f  = PH_F_CMD8;
              end else if (budget_t != '0) begin
                act = ACT_SEND;
              end else begin
                retry_en = 1'b1;
                retry_f  = PH_F_CMD8;
              end
            end
            PH_RTOK: begin
              budget_d = budget_t;
              act      = ACT_SEND;
              if ((c == DATA_TOKEN) || (budget_t == '0)) begin
                if ((c != DATA_TOKEN) && (fail_d == ST_OK)) begin
                  fail_d = ST_DATA_TIMEOUT;
                end
                phase_d = PH_RDATA;
                bc_d    = '0;
              end
            end
            PH_RDATA: begin
              bc_d = bc_inc;
              if (bc_inc >= BLK) begin
                phase_d = PH_IDLE;
                act     = ACT_DATA_FINISH;
              end else begin
                act = ACT_DATA_SEND;
              end
            end
            PH_WGAP: begin
              phase_d = PH_WTOK;
              act     = ACT_SEND;
              tx      = DATA_TOKEN;
            end
            PH_WTOK: begin
              act = ACT_SEND;
              if (skip_q) begin
                phase_d  = PH_WRESP;
                budget_d = WR_RESP_POLLS;
              end else begin
                phase_d = PH_WDATA;
                bc_d    = '0;
                tx      = rd_data_i;
              end
            end
            PH_WDATA: begin
              act  = ACT_SEND;
              bc_d = bc_inc;
              if (bc_inc < BLK) begin
                tx = rd_data_i;
              end else begin
                phase_d  = PH_WRESP;
                budget_d = WR_RESP_POLLS;
              end
            end
            PH_WRESP: begin
              budget_d = budget_t;
              if ((c == RESP_ACC_A) || (c == RESP_ACC_B)) begin
                phase_d = PH_IDLE;
                act     = ACT_FINISH;
              end else if (budget_t != '0) begin
                act = ACT_SEND;
              end else begin
                if (fail_d == ST_OK) begin
                  fail_d = ST_DATA_TIMEOUT;
                end
                phase_d = PH_IDLE;
                act     = ACT_FINISH;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end

    if (retry_en) begin
      attempt_d = attempt_q + 5'd1;
      if (attempt_d < max_tries(retry_f)) begin
        phase_d = retry_f;
        pos_d   = '0;
        act     = ACT_SEND;
        tx      = frame_byte(retry_f, 3'd0, v2_d, addr_d);
      end else begin
        after_en = 1'b1;
        after_ok = 1'b0;
        after_f  = retry_f;
      end
    end

    if (after_en) begin
      act = ACT_SEND;
      tx  = BYTE_IDLE;
      if (!after_ok && (after_f != PH_F_CMD8) && (fail_d == ST_OK)) begin
        fail_d = ST_CMD_TIMEOUT;
      end
      unique case (after_f)
        PH_F_CMD0: begin
          phase_d = PH_GAP1;
          bc_d    = '0;
        end
        PH_F_CMD8: begin
          if (after_ok) begin
            v2_d = 1'b1;
          end
          if (v2_d) begin
            phase_d = PH_GAP2;
            bc_d    = '0;
          end else begin
            attempt_d = '0;
            phase_d   = PH_F_CMD1;
            pos_d     = '0;
            tx        = CMD1_BYTE;
          end
        end
        PH_F_CMD1: begin
          phase_d = PH_TAIL;
          bc_d    = '0;
        end
        PH_F_RD: begin
          phase_d  = PH_RTOK;
          budget_d = RD_TOKEN_POLLS;
        end
        default: phase_d = PH_WGAP;
      endcase
    end
  end

  // result beats
  always_comb begin
    res_send = '{kind: KIND_SEND, out_byte: tx, byte_index: '0,
                 chip_select_low: (phase_d != PH_DUMMY), status: ST_OK,
                 card_v2: 1'b0, last: 1'b1};
    res_done = '{kind: KIND_DONE, out_byte: '0, byte_index: '0,
                 chip_select_low: 1'b0, status: fail_d,
                 card_v2: (phase_q == PH_TAIL) ? v2_d : 1'b0, last: 1'b1};
    res_data = '{kind: KIND_DATA, out_byte: c, byte_index: 9'(bc_q),
                 chip_select_low: 1'b1, status: ST_OK, card_v2: 1'b0, last: 1'b0};
    push_o   = '0;
    unique case (act)
      ACT_NONE: ;
      ACT_SEND: begin
        push_o.beats = 2'd1;
        push_o.r0    = res_send;
      end
      ACT_FINISH: begin
        push_o.beats = 2'd1;
        push_o.r0    = res_done;
      end
      ACT_DATA_SEND: begin
        push_o.beats = 2'd2;
        push_o.r0    = res_data;
        push_o.r1    = res_send;
      end
      ACT_DATA_FINISH: begin
        push_o.beats = 2'd2;
        push_o.r0    = res_data;
        push_o.r1    = res_done;
      end
      default: ;
    endcase
  end

  assign rd_addr_o = (phase_d == PH_WDATA) ? AW'(CW'(bc_d + 1'b1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= '0;
      budget_q  <= '0;
      attempt_q <= '0;
      bc_q      <= '0;
      skip_q    <= 1'b0;
      v2_q      <= 1'b0;
      fail_q    <= ST_OK;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      budget_q  <= budget_d;
      attempt_q <= attempt_d;
      bc_q      <= bc_d;
      skip_q    <= skip_d;
      v2_q      <= v2_d;
      fail_q    <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((act == ACT_FINISH) || (act == ACT_DATA_FINISH)) |=> (phase_q == PH_IDLE))
    else $error("finish did not return to idle");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_i |=> $stable(phase_q) && $stable(bc_q))
    else $error("sequencer moved without a beat");

  a_data_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((act == ACT_DATA_SEND) || (act == ACT_DATA_FINISH)) |->
      (proc_i && (phase_q == PH_RDATA)))
    else $error("data byte outside block read");

  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && (act == ACT_SEND) |=> (pos_q <= FRAME_LAST))
    else $error("frame position overran");

endmodule

`default_nettype wire

@@ rtl/sdsh_outq.sv @@
// ----------------------------------------------------------------------------
// sdsh_outq
// Four-entry result queue, two beats in and one beat out per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_outq import sdsh_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  result_t       q_q [QD];
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PW:0]   count_q, count_d;
  logic          pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = (count_q <= (PW + 1)'(QD - 2));
  assign res_o       = q_q[head_q];

  always_comb begin
    head_d  = head_q + PW'(pop);
    tail_d  = tail_q + PW'(push_i.beats);
    count_d = count_q + (PW + 1)'(push_i.beats) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.beats != 2'd0) begin
      q_q[tail_q] <= push_i.r0;
    end
    if (push_i.beats == 2'd2) begin
      q_q[PW'(tail_q + 1'b1)] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.beats != 2'd0) |-> space_o)
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW + 1)'(QD))
    else $error("result queue count out of range");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.beats == 2'd0)) |=> (count_q == $past(count_q) - 1'b1))
    else $error("result queue lost a beat");

endmodule

`default_nettype wire

@@ rtl/sd_spi_host_sequencer.sv @@
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card SPI-mode host sequencer: init, block read and block write as a
// stream of byte exchanges.
//
//   channel | direction | beat carries
//   --------+-----------+-------------------------------------------------
//   in      | to block  | request, card reply byte or write buffer load
//   out     | from block| byte to send, received data byte or completion
//
// An accepted beat is registered, decided once the result queue has room,
// and its results are queued as it is decided; a new input beat is taken
// every cycle while the queue has room. A received data byte yields two
// result beats, so during block reads the single output port slows the input.
// Input is held off only when the four-entry result queue has fewer than two
// free slots. Reset clears all control state at once; the write buffer is
// not cleared and reads as whatever was last loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_host_sequencer import sdsh_pkg::*; #(
  parameter int BLOCK_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] block_address_i,
  input  wire logic        skip_data_i,
  input  wire logic [7:0]  card_byte_i,
  input  wire logic [8:0]  load_index_i,
  input  wire logic [7:0]  load_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [8:0]       byte_index_o,
  output logic             chip_select_low_o,
  output logic [1:0]       status_o,
  output logic             card_v2_o,
  output logic             last_o
);

  localparam int AW = $clog2(BLOCK_BYTES);

  item_t         item_q;
  logic          in_valid_q, in_valid_d;
  logic          space, proc, accept;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  push_t         push;
  result_t       res;

  assign proc       = in_valid_q && space;
  assign in_ready_o = !in_valid_q || proc;
  assign accept     = in_valid_i && in_ready_o;
  assign in_valid_d = accept ? 1'b1 : (proc ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{opcode: opcode_i, block_address: block_address_i,
                  skip_data: skip_data_i, card_byte: card_byte_i,
                  load_index: load_index_i, load_data: load_data_i};
    end
  end

  sdsh_wbuf #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_wbuf (
    .clk_i        (clk_i),
    .load_en_i    (proc && (item_q.opcode == OP_LOAD)),
    .load_index_i (item_q.load_index),
    .load_data_i  (item_q.load_data),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

  sdsh_core #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (proc),
    .item_i    (item_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .push_o    (push)
  );

  sdsh_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o            = res.kind;
  assign out_byte_o        = res.out_byte;
  assign byte_index_o      = res.byte_index;
  assign chip_select_low_o = res.chip_select_low;
  assign status_o          = res.status;
  assign card_v2_o         = res.card_v2;
  assign last_o            = res.last;

endmodule

`default_nettype wire
